/* sv/assert_macros.svh */
// Assertion macros shared by the display window decode RTL.
// Plain text macros; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low, with a fixed report.
`define DWGD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dwgd assertion failed");

// Same, with a caller-supplied message string.
`define DWGD_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

`endif

/* sv/dwgd_pkg.sv */
// Types and constants for the display window geometry decode.
// No dependencies; used by the interfaces, the decode and the top level.
package dwgd_pkg;

    localparam int unsigned GEOM_W     = 11;
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // End of the visible lines: the vertical stop is clamped to it, a start at or past it holds
    localparam logic [GEOM_W-1:0] MAX_LINES = 11'd313;

    // Register index for the configuration port
    localparam logic [0:0] REG_ECS_CHIP = 1'b0;

    typedef struct packed {
        logic [GEOM_W-1:0] left;
        logic [GEOM_W-1:0] right;
        logic [GEOM_W-1:0] top;
        logic [GEOM_W-1:0] bottom;
        logic [GEOM_W-1:0] width;
        logic [GEOM_W-1:0] height;
    } t_geom;

    localparam t_geom GEOM_RESET = '{
        left:   11'd0,
        right:  11'd320,
        top:    11'd0,
        bottom: 11'd256,
        width:  11'd320,
        height: 11'd256
    };

    typedef struct packed {
        logic [FIELD_W-1:0] window_start;
        logic [FIELD_W-1:0] window_stop;
        logic [FIELD_W-1:0] window_high;
        logic [FIELD_W-1:0] bitplane_control;
    } t_regs;

endpackage

/* sv/dwgd_in_if.sv */
// Input channel: one beat carries the four window/bitplane register values.
// Depends on dwgd_pkg.
interface dwgd_in_if import dwgd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] window_start;
    logic [FIELD_W-1:0] window_stop;
    logic [FIELD_W-1:0] window_high;
    logic [FIELD_W-1:0] bitplane_control;

    modport source (output valid, window_start, window_stop, window_high,
                    bitplane_control, input ready);
    modport sink   (input valid, window_start, window_stop, window_high,
                    bitplane_control, output ready);
endinterface

/* sv/dwgd_out_if.sv */
// Output channel: one beat carries the latched window geometry and held flag.
// Depends on dwgd_pkg.
interface dwgd_out_if import dwgd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GEOM_W-1:0] left_edge;
    logic [GEOM_W-1:0] right_edge;
    logic [GEOM_W-1:0] top_line;
    logic [GEOM_W-1:0] bottom_line;
    logic [GEOM_W-1:0] frame_width;
    logic [GEOM_W-1:0] frame_height;
    logic              held;

    modport source (output valid, left_edge, right_edge, top_line, bottom_line,
                    frame_width, frame_height, held, input ready);
    modport sink   (input valid, left_edge, right_edge, top_line, bottom_line,
                    frame_width, frame_height, held, output ready);
endinterface

/* sv/display_window_geometry_decode_unit.sv */
// Display window geometry decode, top level: APB config, in/out channels.
// Result beat is registered from the accepted input beat; throughput one beat/cycle unless the result stalls.
// Decode runs in one combinational pass into the kept geometry registers.
// Input is taken whenever the result register is empty or being drained.
// Synchronous active-low reset: ecs_chip 0, geometry 0/320/0/256/320/256.
// Depends on dwgd_pkg, dwgd_in_if, dwgd_out_if, dwgd_decode, assert_macros.svh.
`include "assert_macros.svh"

module display_window_geometry_decode_unit import dwgd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dwgd_in_if.sink               i_item,
    dwgd_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic  r_ecs_chip;
    t_geom r_geom;
    logic  r_held;
    logic  r_out_valid;

    t_geom n_geom;
    logic  n_held;
    t_regs regs;
    logic  in_fire, cfg_wr, reg_sel;

    // registers sit on 4-byte steps; bit 2 selects the register
    assign reg_sel = (paddr[2:2] == REG_ECS_CHIP);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {{(APB_DATA_W-1){1'b0}}, r_ecs_chip} : '0;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign in_fire      = i_item.valid && i_item.ready;

    assign regs.window_start     = i_item.window_start;
    assign regs.window_stop      = i_item.window_stop;
    assign regs.window_high      = i_item.window_high;
    assign regs.bitplane_control = i_item.bitplane_control;

    dwgd_decode u_decode (
        .i_ecs_chip (r_ecs_chip),
        .i_regs     (regs),
        .i_kept     (r_geom),
        .o_geom     (n_geom),
        .o_held     (n_held)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecs_chip  <= 1'b0;
            r_geom      <= GEOM_RESET;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_ecs_chip <= pwdata[0];
            end
            if (in_fire) begin
                r_geom      <= n_geom;
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // kept geometry doubles as the result payload
    assign o_result.valid        = r_out_valid;
    assign o_result.left_edge    = r_geom.left;
    assign o_result.right_edge   = r_geom.right;
    assign o_result.top_line     = r_geom.top;
    assign o_result.bottom_line  = r_geom.bottom;
    assign o_result.frame_width  = r_geom.width;
    assign o_result.frame_height = r_geom.height;
    assign o_result.held         = r_held;

    `DWGD_ASSERT(a_beat_makes_result, i_clk, i_rst_n, in_fire |=> r_out_valid)
    `DWGD_ASSERT_MSG(a_held_keeps_geom, i_clk, i_rst_n,
        (in_fire && n_held) |=> $stable(r_geom), "held beat changed geometry")
    `DWGD_ASSERT_MSG(a_stall_keeps_geom, i_clk, i_rst_n,
        (r_out_valid && !o_result.ready) |=> ($stable(r_geom) && r_out_valid),
        "stalled result changed")
    `DWGD_ASSERT_MSG(a_bottom_clamped, i_clk, i_rst_n,
        r_geom.bottom <= MAX_LINES, "bottom line past last line")
    `DWGD_ASSERT(a_geom_nonzero, i_clk, i_rst_n,
        (r_geom.width != '0) && (r_geom.height != '0))

endmodule

/* sv/dwgd_decode.sv */
// Combinational window decode: register values plus kept geometry in,
// next geometry and held flag out. Depends on dwgd_pkg.
module dwgd_decode import dwgd_pkg::*; (
    input  logic  i_ecs_chip,
    input  t_regs i_regs,
    input  t_geom i_kept,
    output t_geom o_geom,
    output logic  o_held
);

    logic        hires, depth_zero, start_ones, have_geom, ext;
    logic [8:0]  hs0, he0, hs2, he2;
    logic [10:0] vs0, ve0;
    logic [11:0] ve1, ve2, ve3;
    logic [9:0]  he1, hspan1, span;
    logic [11:0] vspan1;
    logic        fallback, short_top, past_last;
    logic [10:0] left_s, span_s, height;
    t_geom       fresh;

    always_comb begin
        hires      = i_regs.bitplane_control[15];
        depth_zero = (i_regs.bitplane_control != '0) &&
                     (i_regs.bitplane_control[14:12] == 3'd0);
        start_ones = (i_regs.window_start == 16'hFFFF);
        have_geom  = (i_kept.width != '0) && (i_kept.height != '0);
        ext        = i_ecs_chip && (i_regs.window_high != '0);

        if (ext) begin
            hs0 = {i_regs.window_high[5], i_regs.window_start[7:0]};
            vs0 = {i_regs.window_high[2:0], i_regs.window_start[15:8]};
            he0 = {i_regs.window_high[13], i_regs.window_stop[7:0]};
            ve0 = {i_regs.window_high[10:8], i_regs.window_stop[15:8]};
        end else begin
            // original form: horizontal stop bit 8 implied set
            hs0 = {1'b0, i_regs.window_start[7:0]};
            vs0 = {3'b0, i_regs.window_start[15:8]};
            he0 = {1'b1, i_regs.window_stop[7:0]};
            ve0 = {3'b0, i_regs.window_stop[15:8]};
        end

        // stops not past the start wrap by 256
        ve1 = (ve0 <= vs0) ? ({1'b0, ve0} + 12'd256) : {1'b0, ve0};
        he1 = (he0 <= hs0) ? ({1'b0, he0} + 10'd256) : {1'b0, he0};

        hspan1   = he1 - {1'b0, hs0};
        fallback = ext && (he1 > {1'b0, hs0}) && (hspan1 > 10'd512);
        if (fallback) begin
            // bit 8 set keeps the stop above any 8-bit start
            hs2 = {1'b0, i_regs.window_start[7:0]};
            he2 = {1'b1, i_regs.window_stop[7:0]};
        end else begin
            hs2 = hs0;
            he2 = he1[8:0];
        end
        // he1 can exceed 9 bits only when no fallback and ext; keep full span
        span = fallback ? ({1'b0, he2} - {1'b0, hs2})
             : ((he1 > {1'b0, hs0}) ? hspan1 : 10'd320);

        vspan1    = ve1 - {1'b0, vs0};
        short_top = !ext && (vspan1 < 12'd128) && (vs0 < 11'd32);
        ve2       = short_top ? ({1'b0, vs0} + 12'd256) : ve1;

        past_last = (vs0 >= MAX_LINES);
        ve3       = (ve2 > {1'b0, MAX_LINES}) ? {1'b0, MAX_LINES} : ve2;

        left_s = hires ? {1'b0, hs2, 1'b0} : {2'b0, hs2};
        span_s = hires ? {span, 1'b0} : {1'b0, span};
        height = (ve3 > {1'b0, vs0}) ? 11'(ve3 - {1'b0, vs0}) : 11'd256;

        fresh.left   = left_s;
        fresh.right  = left_s + span_s;
        fresh.top    = vs0;
        fresh.bottom = ve3[10:0];
        fresh.width  = span_s;
        fresh.height = height;

        o_held = ((depth_zero || start_ones) && have_geom) || past_last;
        o_geom = o_held ? i_kept : fresh;
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench for display_window_geometry_decode_unit: directed and random window beats,
// checked against an in-bench decode of the window registers. Drives the APB port too.
// Depends on dwgd_pkg, dwgd_in_if, dwgd_out_if and the top level.
module tb;
    import dwgd_pkg::*;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned TIMEOUT_CYCLES = 200_000;
    localparam int unsigned DRAIN_LIMIT    = 1000;
    localparam int unsigned HOLD_OFF_LEN   = 200;
    localparam int unsigned RANDOM_PER_MIX = 220;
    localparam logic [APB_ADDR_W-1:0] ECS_ADDR = APB_ADDR_W'({REG_ECS_CHIP, 2'b00});

    typedef struct packed {
        t_geom geom;
        logic  held;
    } t_window_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dwgd_in_if  item_if ();
    dwgd_out_if result_if ();

    display_window_geometry_decode_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the block's latched geometry and chip mode
    t_geom          shadow_geom;
    logic           shadow_ecs;
    t_window_result expected_geom_q[$];

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    bit          hold_request;
    logic        long_hold;
    int unsigned errors;
    int unsigned beats_sent;
    int unsigned results_checked;
    int unsigned held_seen;

    always begin
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
    end

    initial begin : run_limit
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("display_window_geometry_decode_unit test failed");
        $finish;
    end

    function automatic void decode_window(input t_regs r, output t_window_result res);
        int unsigned hs, he, vs, ve, scale, span;
        logic [7:0]  lo, hi;
        bit          ext, have_geom, hold;
        have_geom = (shadow_geom.width != '0) && (shadow_geom.height != '0);
        hold = have_geom && ((r.bitplane_control != '0 && r.bitplane_control[14:12] == 3'd0)
                             || r.window_start == 16'hFFFF);
        ext = shadow_ecs && (r.window_high != '0);
        lo  = r.window_high[7:0];
        hi  = r.window_high[15:8];
        if (ext) begin
            hs = {lo[5], r.window_start[7:0]};
            vs = {lo[2:0], r.window_start[15:8]};
            he = {hi[5], r.window_stop[7:0]};
            ve = {hi[2:0], r.window_stop[15:8]};
        end else begin
            hs = r.window_start[7:0];
            vs = r.window_start[15:8];
            he = r.window_stop[7:0] + 256;   // original form: stop bit 8 implied
            ve = r.window_stop[15:8];
        end
        if (ve <= vs) ve += 256;
        if (he <= hs) he += 256;
        // extended span too wide: redo horizontal in original form
        if (ext && he > hs && (he - hs) > 512) begin
            hs = r.window_start[7:0];
            he = r.window_stop[7:0] + 256;
            if (he <= hs) he += 256;
        end
        if (!ext && ((ve - vs) & 32'hFFFF) < 128 && vs < 32)
            ve = vs + 256;
        if (vs >= MAX_LINES) hold = 1'b1;
        if (!hold) begin
            if (ve > MAX_LINES) ve = MAX_LINES;
            scale = r.bitplane_control[15] ? 2 : 1;
            span  = (he > hs) ? (he - hs) : 320;
            shadow_geom.left   = GEOM_W'(hs * scale);
            shadow_geom.right  = GEOM_W'(shadow_geom.left + span * scale);
            shadow_geom.top    = GEOM_W'(vs);
            shadow_geom.bottom = GEOM_W'(ve);
            shadow_geom.width  = GEOM_W'(span * scale);
            shadow_geom.height = GEOM_W'((ve > vs) ? (ve - vs) : 256);
        end
        res.geom = shadow_geom;
        res.held = hold;
    endfunction

    function automatic void check_field(input string name, input logic [GEOM_W-1:0] want,
                                        input logic [GEOM_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Checks result beats against the oldest expectation, then predicts new input beats
    always @(posedge i_clk) begin : beat_monitor
        t_window_result want;
        t_window_result predicted;
        t_regs          regs;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                if (expected_geom_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got left %0d",
                             $time, result_if.left_edge);
                    errors++;
                end else begin
                    want = expected_geom_q.pop_front();
                    check_field("left_edge",    want.geom.left,   result_if.left_edge);
                    check_field("right_edge",   want.geom.right,  result_if.right_edge);
                    check_field("top_line",     want.geom.top,    result_if.top_line);
                    check_field("bottom_line",  want.geom.bottom, result_if.bottom_line);
                    check_field("frame_width",  want.geom.width,  result_if.frame_width);
                    check_field("frame_height", want.geom.height, result_if.frame_height);
                    check_field("held", GEOM_W'(want.held), GEOM_W'(result_if.held));
                    results_checked++;
                    if (want.held) held_seen++;
                end
            end
            if (item_if.valid && item_if.ready) begin
                regs.window_start     = item_if.window_start;
                regs.window_stop      = item_if.window_stop;
                regs.window_high      = item_if.window_high;
                regs.bitplane_control = item_if.bitplane_control;
                decode_window(regs, predicted);
                expected_geom_q.push_back(predicted);
                beats_sent++;
            end
        end
    end

    always @(posedge i_clk) begin : result_ready_drive
        result_if.ready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end

    // Long output hold-off, counted here so the sender keeps offering beats meanwhile
    initial begin : long_hold_counter
        long_hold = 1'b0;
        forever begin
            wait (hold_request);
            @(posedge i_clk);
            long_hold <= 1'b1;
            repeat (HOLD_OFF_LEN) @(posedge i_clk);
            long_hold <= 1'b0;
            hold_request = 1'b0;
        end
    end

    task automatic send_item(input logic [15:0] start, input logic [15:0] stop,
                             input logic [15:0] high, input logic [15:0] ctrl);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid            <= 1'b1;
        item_if.window_start     <= start;
        item_if.window_stop      <= stop;
        item_if.window_high      <= high;
        item_if.bitplane_control <= ctrl;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    task automatic send_random_item();
        logic [15:0] start, stop, high, ctrl;
        start = 16'($urandom);
        if ($urandom_range(19) == 0) start = 16'hFFFF;
        stop = 16'($urandom);
        case ($urandom_range(9))
            0, 1, 2: high = '0;
            3, 4:    high = 16'($urandom);
            default: begin
                // keep vertical extension mostly small so the window stays on screen
                high = 16'($urandom) & 16'h2727;
                if ($urandom_range(3) != 0) begin
                    high[2:0]  = 3'($urandom_range(1));
                    high[10:8] = 3'($urandom_range(1));
                end
            end
        endcase
        case ($urandom_range(9))
            0:       ctrl = '0;
            1:       ctrl = 16'($urandom) & 16'h8FFF;
            default: begin
                ctrl = 16'($urandom);
                if (ctrl[14:12] == 3'd0) ctrl[12] = 1'b1;
            end
        endcase
        send_item(start, stop, high, ctrl);
    endtask

    task automatic wait_results_drained();
        int unsigned waited;
        item_if.valid <= 1'b0;
        waited = 0;
        repeat (2) @(posedge i_clk);
        while (expected_geom_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_geom_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_geom_q.size());
            errors += expected_geom_q.size();
            expected_geom_q.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ECS_ADDR) shadow_ecs = data[0];
    endtask

    task automatic cfg_read_check(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $display("%0t: register read mismatch: expected %0h, got %0h", $time, want, got);
            errors++;
        end
    endtask

    task automatic set_ecs(input logic [APB_DATA_W-1:0] value);
        wait_results_drained();
        cfg_write(ECS_ADDR, value);
        // leave the bus idle between the write and the readback
        @(posedge i_clk);
        cfg_read_check(ECS_ADDR, APB_DATA_W'(shadow_ecs));
    endtask

    task automatic test_config_access();
        cfg_read_check(ECS_ADDR, '0);
        set_ecs(32'h0000_0001);
        set_ecs(32'hFFFF_FFFE);    // only bit 0 sticks
        set_ecs(32'hFFFF_FFFF);
        set_ecs(32'h0000_0000);
    endtask

    task automatic test_original_form();
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero control still decodes
        send_item(16'h2C81, 16'h2CC1, 16'h0000, 16'h2000);
        send_item(16'h1000, 16'h2000, 16'h0000, 16'h1000);  // short top window
        send_item(16'h1F00, 16'h9E00, 16'h0000, 16'h1000);
        send_item(16'h2000, 16'h9F00, 16'h0000, 16'h1000);
        send_item(16'hFFFF, 16'h2CC1, 16'h0000, 16'h1000);  // start all ones holds
        send_item(16'h2C81, 16'h2CC1, 16'h0000, 16'h8000);  // zero depth holds
        send_item(16'h2C81, 16'h2CC1, 16'h0000, 16'h9000);  // hires
        send_item(16'hFF00, 16'hFFFF, 16'hFFFF, 16'hF000);  // high ignored on original chip
        send_item(16'h00FF, 16'hFF00, 16'h0000, 16'h7000);
        send_item(16'h2C81, 16'h2C81, 16'h0000, 16'h2000);
        send_item(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        wait_results_drained();
    endtask

    task automatic test_extended_form();
        set_ecs(32'h0000_0001);
        send_item(16'h2C81, 16'h2CC1, 16'h0000, 16'h2000);  // high zero: original form
        send_item(16'h2C81, 16'h2CC1, 16'h2000, 16'h2000);
        send_item(16'h3800, 16'h0000, 16'h0201, 16'h1000);  // last line start, stop clamped
        send_item(16'h3900, 16'h0000, 16'h0001, 16'h1000);  // start past last line holds
        send_item(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hF000);
        send_item(16'h00FF, 16'h0000, 16'h2020, 16'h9000);  // stop wraps past start
        send_item(16'h0000, 16'h00FF, 16'h2000, 16'h9000);  // widest span, hires
        send_item(16'h1000, 16'h2000, 16'h0100, 16'h1000);  // no short-window stretch here
        send_item(16'h1000, 16'h1000, 16'h0100, 16'h1000);
        send_item(16'h0800, 16'h0400, 16'h0004, 16'h1000);
        send_item(16'hFFFF, 16'h0000, 16'h0101, 16'h1000);
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (40) send_random_item();
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned idle_mix[4]  = '{0, 62, 0, 30};
        int unsigned stall_mix[4] = '{0, 0, 62, 30};
        for (int ecs = 0; ecs < 2; ecs++) begin
            set_ecs(APB_DATA_W'(ecs));
            for (int m = 0; m < 4; m++) begin
                send_idle_pct = idle_mix[m];
                stall_pct     = stall_mix[m];
                repeat (RANDOM_PER_MIX) send_random_item();
            end
        end
        send_idle_pct = 0;
        stall_pct     = 0;
        wait_results_drained();
    endtask

    initial begin : main_seq
        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        item_if.valid            = 1'b0;
        item_if.window_start     = '0;
        item_if.window_stop      = '0;
        item_if.window_high      = '0;
        item_if.bitplane_control = '0;
        result_if.ready          = 1'b0;
        send_idle_pct            = 0;
        stall_pct                = 0;
        hold_request             = 1'b0;
        errors                   = 0;
        beats_sent               = 0;
        results_checked          = 0;
        held_seen                = 0;
        shadow_geom              = GEOM_RESET;
        shadow_ecs               = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_config_access();
        test_original_form();
        test_extended_form();
        test_output_backpressure();
        test_random_traffic();

        $display("Covered: %0d input beats, %0d results checked (%0d held),", beats_sent,
                 results_checked, held_seen);
        $display("both chip modes, four idle/stall mixes and one long output hold-off.");
        if (errors == 0) begin
            $display("display_window_geometry_decode_unit test passed");
        end else begin
            $display("display_window_geometry_decode_unit test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/dwgd_pkg.sv
sv/dwgd_in_if.sv
sv/dwgd_out_if.sv
sv/dwgd_decode.sv
sv/display_window_geometry_decode_unit.sv
tb/sv/tb.sv
